FILE: rtl/core/cea_pkg.sv
// shared types, codes and constants for the execute stage alu
package cea_pkg;

	localparam int DataWidth = 32;

	// instruction classes
	localparam logic [5:0] ClsLoadImm   = 6'd0;
	localparam logic [5:0] ClsAluImm    = 6'd1;
	localparam logic [5:0] ClsAluReg    = 6'd2;
	localparam logic [5:0] ClsPairImm   = 6'd3;
	localparam logic [5:0] ClsPairReg   = 6'd4;
	localparam logic [5:0] ClsNegNot    = 6'd5;
	localparam logic [5:0] ClsJump      = 6'd6;
	localparam logic [5:0] ClsBrImmLo   = 6'd7;
	localparam logic [5:0] ClsBrRegLo   = 6'd13;
	localparam logic [5:0] ClsBrZeroLo  = 6'd19;
	localparam logic [5:0] ClsBrZeroHi  = 6'd24;
	localparam logic [5:0] ClsJumpReg   = 6'd25;
	localparam logic [5:0] ClsJumpLink  = 6'd26;
	localparam logic [5:0] ClsJumpRegLk = 6'd27;
	localparam logic [5:0] ClsAddrGen   = 6'd28;
	localparam logic [5:0] ClsMove      = 6'd29;
	localparam logic [5:0] ClsReadFirst = 6'd30;
	localparam logic [5:0] ClsReadSec   = 6'd31;

	// alu sub-operations
	localparam logic [4:0] FnAdd  = 5'd0;
	localparam logic [4:0] FnSub  = 5'd1;
	localparam logic [4:0] FnMul  = 5'd2;
	localparam logic [4:0] FnDiv  = 5'd3;
	localparam logic [4:0] FnRem  = 5'd4;
	localparam logic [4:0] FnXor  = 5'd5;
	localparam logic [4:0] FnSeq  = 5'd6;
	localparam logic [4:0] FnSgt  = 5'd11;
	localparam logic [4:0] FnAddu = 5'd12;
	localparam logic [4:0] FnSubu = 5'd13;
	localparam logic [4:0] FnMulu = 5'd14;
	localparam logic [4:0] FnDivu = 5'd15;
	localparam logic [4:0] FnRemu = 5'd16;
	localparam logic [4:0] FnXoru = 5'd17;

	// pair sub-operations
	localparam logic [4:0] PfSmul = 5'd0;
	localparam logic [4:0] PfSdiv = 5'd1;
	localparam logic [4:0] PfUmul = 5'd2;
	localparam logic [4:0] PfUdiv = 5'd3;

	// negate/not sub-operations, any code but negate gives not
	localparam logic [4:0] NnNeg = 5'd0;
	localparam logic [4:0] NnNot = 5'd1;

	// compare codes
	localparam logic [2:0] CmpEq = 3'd0;
	localparam logic [2:0] CmpNe = 3'd1;
	localparam logic [2:0] CmpLe = 3'd2;
	localparam logic [2:0] CmpLt = 3'd3;
	localparam logic [2:0] CmpGe = 3'd4;

	typedef struct packed {
		logic [5:0]  op_class;
		logic [4:0]  func;
		logic signed [31:0] src_a;
		logic signed [31:0] src_b;
		logic signed [31:0] immediate;
		logic [31:0] jump_target;
		logic [31:0] next_pc;
		logic        use_base;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] result;
		logic        branch_taken;
		logic        link_write;
		logic        div_zero;
	} out_item_t;

	// result forms the controller asks the datapath to finish with
	typedef enum logic [2:0] {
		KIND_DIRECT = 3'd0,
		KIND_MUL    = 3'd1,
		KIND_DIV    = 3'd2
	} op_kind_t;

	// controller to datapath
	typedef struct packed {
		logic load;       // capture input item and decode
		logic mul_step;   // multiplier partial product step
		logic div_start;  // prepare divider operands
		logic div_step;   // one quotient bit
		logic finish;     // form the result item
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		op_kind_t kind;
		logic     div_last;
	} dp_stat_t;

	// signed compare on a code
	function automatic logic scmp(input logic [2:0] code, input logic [31:0] a,
			input logic [31:0] b);
		logic lt;
		logic eq;
		begin
			lt = $signed(a) < $signed(b);
			eq = a == b;
			case (code)
				CmpEq:   scmp = eq;
				CmpNe:   scmp = !eq;
				CmpLe:   scmp = lt | eq;
				CmpLt:   scmp = lt;
				CmpGe:   scmp = !lt;
				default: scmp = !(lt | eq);
			endcase
		end
	endfunction

endpackage

FILE: rtl/core/cea_ctrl.sv
// controller state machine for the execute stage alu
module cea_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  cea_pkg::dp_stat_t    stat,
	output cea_pkg::dp_cmd_t     cmd
);

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_DEC   = 6'b000010,
		ST_MUL   = 6'b000100,
		ST_DPREP = 6'b001000,
		ST_DIV   = 6'b010000,
		ST_FIN   = 6'b100000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	// output register may be refilled when empty or being taken
	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = state_q == ST_IDLE;
	assign out_valid = out_valid_q;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_DEC;
				end
			end
			ST_DEC: begin
				case (stat.kind)
					cea_pkg::KIND_MUL: state_d = ST_MUL;
					cea_pkg::KIND_DIV: state_d = ST_DPREP;
					default:           state_d = ST_FIN;
				endcase
			end
			ST_MUL: begin
				cmd.mul_step = 1'b1;
				state_d      = ST_FIN;
			end
			ST_DPREP: begin
				cmd.div_start = 1'b1;
				state_d       = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_last) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (out_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state and output valid registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: rtl/core/cea_dpath.sv
// datapath: operand capture, multiplier, radix-2 divider, result mux, pair state
module cea_dpath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cea_pkg::in_item_t    in_item,
	input  cea_pkg::dp_cmd_t     cmd,
	output cea_pkg::dp_stat_t    stat,
	output cea_pkg::out_item_t   out_item
);

	cea_pkg::in_item_t  item_q;
	cea_pkg::out_item_t out_q;
	logic [31:0] pair_first_q, pair_second_q;
	logic [31:0] opb;
	logic        is_alu, is_pair;
	logic        mul_signed, is_div_op;
	logic [63:0] prod_q;
	logic [31:0] pp_ll_q, pp_lh_q, pp_hl_q;
	logic [31:0] pp_hh_q;
	logic [31:0] dvd_q, quo_q;
	logic [32:0] rem_q;
	logic [31:0] dvs_q;
	logic [4:0]  cnt_q;
	logic        neg_q_q, neg_r_q;
	logic [31:0] abs_a, abs_b;
	logic        div_signed;
	logic [32:0] rem_sh, rem_sub;
	logic [31:0] quo_fix, rem_fix;
	logic        dz;
	logic [63:0] prod_full;
	cea_pkg::out_item_t fin;

	// operand and decode of the held item
	assign is_alu  = item_q.op_class == cea_pkg::ClsAluImm
		|| item_q.op_class == cea_pkg::ClsAluReg;
	assign is_pair = item_q.op_class == cea_pkg::ClsPairImm
		|| item_q.op_class == cea_pkg::ClsPairReg;
	assign opb = (item_q.op_class == cea_pkg::ClsAluImm
		|| item_q.op_class == cea_pkg::ClsPairImm) ? item_q.immediate : item_q.src_b;
	assign is_div_op = (is_alu && (item_q.func == cea_pkg::FnDiv
		|| item_q.func == cea_pkg::FnRem || item_q.func == cea_pkg::FnDivu
		|| item_q.func == cea_pkg::FnRemu))
		|| (is_pair && (item_q.func == cea_pkg::PfSdiv || item_q.func == cea_pkg::PfUdiv));
	assign div_signed = is_alu ? (item_q.func == cea_pkg::FnDiv
		|| item_q.func == cea_pkg::FnRem) : item_q.func == cea_pkg::PfSdiv;
	assign mul_signed = is_pair && item_q.func == cea_pkg::PfSmul;

	always_comb begin
		stat.kind     = cea_pkg::KIND_DIRECT;
		stat.div_last = cnt_q == 5'd31;
		if (is_div_op) begin
			stat.kind = cea_pkg::KIND_DIV;
		end else if ((is_alu && (item_q.func == cea_pkg::FnMul
				|| item_q.func == cea_pkg::FnMulu))
				|| (is_pair && (item_q.func == cea_pkg::PfSmul
				|| item_q.func == cea_pkg::PfUmul))) begin
			stat.kind = cea_pkg::KIND_MUL;
		end
	end

	// divider magnitudes
	assign abs_a = (div_signed && item_q.src_a[31]) ? 32'(-item_q.src_a) : item_q.src_a;
	assign abs_b = (div_signed && opb[31]) ? 32'(-opb) : opb;
	assign rem_sh  = {rem_q[31:0], dvd_q[31]};
	assign rem_sub = rem_sh - {1'b0, dvs_q};
	assign quo_fix = neg_q_q ? 32'(-quo_q) : quo_q;
	assign rem_fix = neg_r_q ? 32'(-rem_q[31:0]) : rem_q[31:0];
	assign dz = is_div_op && opb == 32'd0;

	// unsigned 16x16 partials summed into the product; signed fix on the high word
	assign prod_full = {32'd0, pp_ll_q} + {16'd0, pp_lh_q, 16'd0}
		+ {16'd0, pp_hl_q, 16'd0} + {pp_hh_q, 32'd0};

	// item capture, multiplier partials, divider iteration
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= in_item;
			pp_ll_q <= 32'(in_item.src_a[15:0]) * 32'(
				(in_item.op_class == cea_pkg::ClsAluImm
				|| in_item.op_class == cea_pkg::ClsPairImm)
				? in_item.immediate[15:0] : in_item.src_b[15:0]);
		end
		if (cmd.load) begin
			pp_lh_q <= 32'(in_item.src_a[15:0]) * 32'(
				(in_item.op_class == cea_pkg::ClsAluImm
				|| in_item.op_class == cea_pkg::ClsPairImm)
				? in_item.immediate[31:16] : in_item.src_b[31:16]);
			pp_hl_q <= 32'(in_item.src_a[31:16]) * 32'(
				(in_item.op_class == cea_pkg::ClsAluImm
				|| in_item.op_class == cea_pkg::ClsPairImm)
				? in_item.immediate[15:0] : in_item.src_b[15:0]);
			pp_hh_q <= 32'(in_item.src_a[31:16]) * 32'(
				(in_item.op_class == cea_pkg::ClsAluImm
				|| in_item.op_class == cea_pkg::ClsPairImm)
				? in_item.immediate[31:16] : in_item.src_b[31:16]);
		end
		if (cmd.mul_step) begin
			prod_q <= {prod_full[63:32]
				- (mul_signed && item_q.src_a[31] ? opb : 32'd0)
				- (mul_signed && opb[31] ? item_q.src_a : 32'd0), prod_full[31:0]};
		end
		if (cmd.div_start) begin
			dvd_q   <= abs_a;
			dvs_q   <= abs_b;
			rem_q   <= '0;
			quo_q   <= '0;
			cnt_q   <= '0;
			neg_q_q <= div_signed && (item_q.src_a[31] ^ opb[31]);
			neg_r_q <= div_signed && item_q.src_a[31];
		end else if (cmd.div_step) begin
			dvd_q <= {dvd_q[30:0], 1'b0};
			cnt_q <= cnt_q + 5'd1;
			if (!rem_sub[32]) begin
				rem_q <= rem_sub;
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
		if (cmd.finish) begin
			out_q <= fin;
		end
	end

	// result selection
	always_comb begin
		fin = '0;
		fin.div_zero = dz;
		case (item_q.op_class) inside
			cea_pkg::ClsLoadImm: fin.result = item_q.immediate;
			cea_pkg::ClsAluImm, cea_pkg::ClsAluReg: begin
				case (item_q.func) inside
					cea_pkg::FnAdd, cea_pkg::FnAddu:
						fin.result = item_q.src_a + opb;
					cea_pkg::FnSub, cea_pkg::FnSubu:
						fin.result = item_q.src_a - opb;
					cea_pkg::FnMul, cea_pkg::FnMulu: fin.result = prod_q[31:0];
					cea_pkg::FnDiv, cea_pkg::FnDivu:
						fin.result = dz ? 32'd0 : quo_fix;
					cea_pkg::FnRem, cea_pkg::FnRemu:
						fin.result = dz ? 32'd0 : rem_fix;
					cea_pkg::FnXor, cea_pkg::FnXoru: fin.result = item_q.src_a ^ opb;
					[cea_pkg::FnSeq:cea_pkg::FnSgt]:
						fin.result = 32'(cea_pkg::scmp(3'(item_q.func - cea_pkg::FnSeq),
							item_q.src_a, opb));
					default: fin.result = '0;
				endcase
			end
			cea_pkg::ClsNegNot:
				fin.result = (item_q.func == cea_pkg::NnNeg) ? -item_q.src_a : ~item_q.src_a;
			cea_pkg::ClsJump: fin.result = item_q.jump_target;
			[cea_pkg::ClsBrImmLo:cea_pkg::ClsBrZeroHi]: begin
				fin.result = item_q.jump_target;
				if (item_q.op_class < cea_pkg::ClsBrRegLo) begin
					fin.branch_taken = cea_pkg::scmp(3'(item_q.op_class - cea_pkg::ClsBrImmLo),
						item_q.src_a, item_q.immediate);
				end else if (item_q.op_class < cea_pkg::ClsBrZeroLo) begin
					fin.branch_taken = cea_pkg::scmp(3'(item_q.op_class - cea_pkg::ClsBrRegLo),
						item_q.src_a, item_q.src_b);
				end else begin
					fin.branch_taken = cea_pkg::scmp(3'(item_q.op_class - cea_pkg::ClsBrZeroLo),
						item_q.src_a, 32'd0);
				end
			end
			cea_pkg::ClsJumpReg, cea_pkg::ClsMove: fin.result = item_q.src_a;
			cea_pkg::ClsJumpLink, cea_pkg::ClsJumpRegLk: begin
				fin.result     = item_q.next_pc;
				fin.link_write = 1'b1;
			end
			cea_pkg::ClsAddrGen:
				fin.result = item_q.use_base ? item_q.src_b + item_q.immediate
					: item_q.immediate;
			cea_pkg::ClsReadFirst: fin.result = pair_first_q;
			cea_pkg::ClsReadSec:   fin.result = pair_second_q;
			default: fin.result = '0;
		endcase
	end

	// product/quotient pair state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pair_first_q  <= '0;
			pair_second_q <= '0;
		end else if (cmd.finish && is_pair) begin
			if (item_q.func == cea_pkg::PfSmul || item_q.func == cea_pkg::PfUmul) begin
				pair_first_q  <= prod_q[31:0];
				pair_second_q <= prod_q[63:32];
			end else if (item_q.func == cea_pkg::PfSdiv
					|| item_q.func == cea_pkg::PfUdiv) begin
				pair_first_q  <= dz ? 32'd0 : rem_fix;
				pair_second_q <= dz ? 32'd0 : quo_fix;
			end
		end
	end

	assign out_item = out_q;

endmodule

FILE: rtl/core/cpu_execute_stage_alu.sv
// top level of the execute stage alu
// Execute stage ALU: one instruction item in, one result item out, over valid/ready.
// Simple operations pass through the decode and finish states; multiplies also go
// through a registered set of 16x16 partial products, then one summing step, and
// divides and remainders through the radix-2 restoring divider that retires
// one quotient bit a cycle. Items are handled one at a time; the next item is
// taken once the previous result is in the output register. Multiply and divide
// pair operations update the pair state read back by the pair-read classes.
module cpu_execute_stage_alu (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  cea_pkg::in_item_t    in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output cea_pkg::out_item_t   out_data
);

	cea_pkg::dp_cmd_t  cmd;
	cea_pkg::dp_stat_t stat;

	// sequencing
	cea_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// arithmetic and state
	cea_dpath u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_item  (in_data),
		.cmd      (cmd),
		.stat     (stat),
		.out_item (out_data)
	);

`ifndef ASSERT_OFF
	// one item in flight: no transfer in while a result is being formed
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input taken back to back");

	// link flag never set together with the branch-taken flag
	a_link_only: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.link_write) |-> !out_data.branch_taken)
		else $error("link and branch both set");

	// a waiting result stays valid and unchanged
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
		else $error("result changed while waiting");
`endif

endmodule

FILE: tb/sv/tb.sv
// testbench for the execute stage alu: random and directed instructions checked against a predictor
`timescale 1ns / 1ps
module tb;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	cea_pkg::in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	cea_pkg::out_item_t out_data;

	cpu_execute_stage_alu dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	always #6 clk = ~clk;

	cea_pkg::in_item_t pending_instrs[$];
	cea_pkg::out_item_t expected_results[$];
	logic [31:0] hi_lo_first = '0;
	logic [31:0] hi_lo_second = '0;
	int errors = 0;
	bit stimulus_done = 0;
	bit in_taken = 0;
	int cycle_count = 0;
	int hold_off = 0;
	int stall_left = 0;
	int gap_left = 0;

	// signed compare by branch group order eq, ne, le, lt, ge, gt
	function automatic logic cond_holds(input int code, input logic [31:0] a,
			input logic [31:0] b);
		case (code)
			0: return a == b;
			1: return a != b;
			2: return $signed(a) <= $signed(b);
			3: return $signed(a) < $signed(b);
			4: return $signed(a) >= $signed(b);
			default: return $signed(a) > $signed(b);
		endcase
	endfunction

	// predicted result of one instruction, updates the pair state
	function automatic cea_pkg::out_item_t execute_instr(input cea_pkg::in_item_t it);
		cea_pkg::out_item_t r;
		logic [31:0] a, b, imm;
		logic signed [63:0] sp;
		logic [63:0] up;
		int cls, f;
		r = '0;
		a = it.src_a;
		imm = it.immediate;
		cls = it.op_class;
		f = it.func;
		b = (cls == cea_pkg::ClsAluImm || cls == cea_pkg::ClsPairImm) ? imm : it.src_b;
		if (cls == cea_pkg::ClsLoadImm) begin
			r.result = imm;
		end else if (cls == cea_pkg::ClsAluImm || cls == cea_pkg::ClsAluReg) begin
			case (f)
				cea_pkg::FnAdd, cea_pkg::FnAddu: r.result = a + b;
				cea_pkg::FnSub, cea_pkg::FnSubu: r.result = a - b;
				cea_pkg::FnMul, cea_pkg::FnMulu: r.result = a * b;
				cea_pkg::FnDiv, cea_pkg::FnRem: begin
					if (b == 0) r.div_zero = 1'b1;
					else if (a == 32'h8000_0000 && b == '1)
						r.result = (f == cea_pkg::FnDiv) ? a : 32'd0;
					else if (f == cea_pkg::FnDiv) r.result = $signed(a) / $signed(b);
					else r.result = $signed(a) % $signed(b);
				end
				cea_pkg::FnXor, cea_pkg::FnXoru: r.result = a ^ b;
				cea_pkg::FnDivu: if (b == 0) r.div_zero = 1'b1; else r.result = a / b;
				cea_pkg::FnRemu: if (b == 0) r.div_zero = 1'b1; else r.result = a % b;
				default: begin
					if (f >= cea_pkg::FnSeq && f <= cea_pkg::FnSgt)
						r.result = {31'd0, cond_holds(f - cea_pkg::FnSeq, a, b)};
				end
			endcase
		end else if (cls == cea_pkg::ClsPairImm || cls == cea_pkg::ClsPairReg) begin
			case (f)
				cea_pkg::PfSmul: begin
					sp = $signed(a) * $signed(b);
					{hi_lo_second, hi_lo_first} = sp;
				end
				cea_pkg::PfUmul: begin
					up = {32'd0, a} * {32'd0, b};
					{hi_lo_second, hi_lo_first} = up;
				end
				cea_pkg::PfSdiv, cea_pkg::PfUdiv: begin
					if (b == 0) begin
						r.div_zero = 1'b1;
						hi_lo_first = '0;
						hi_lo_second = '0;
					end else if (f == cea_pkg::PfUdiv) begin
						hi_lo_first = a % b;
						hi_lo_second = a / b;
					end else if (a == 32'h8000_0000 && b == '1) begin
						hi_lo_first = '0;
						hi_lo_second = a;
					end else begin
						hi_lo_first = $signed(a) % $signed(b);
						hi_lo_second = $signed(a) / $signed(b);
					end
				end
				default: ;
			endcase
		end else if (cls == cea_pkg::ClsNegNot) begin
			r.result = (f == cea_pkg::NnNeg) ? -a : ~a;
		end else if (cls == cea_pkg::ClsJump) begin
			r.result = it.jump_target;
		end else if (cls >= cea_pkg::ClsBrImmLo && cls <= cea_pkg::ClsBrZeroHi) begin
			r.result = it.jump_target;
			r.branch_taken = cond_holds((cls - cea_pkg::ClsBrImmLo) % 6, a,
				(cls < cea_pkg::ClsBrRegLo) ? imm
				: (cls < cea_pkg::ClsBrZeroLo) ? it.src_b : 32'd0);
		end else if (cls == cea_pkg::ClsJumpReg || cls == cea_pkg::ClsMove) begin
			r.result = a;
		end else if (cls == cea_pkg::ClsJumpLink || cls == cea_pkg::ClsJumpRegLk) begin
			r.result = it.next_pc;
			r.link_write = 1'b1;
		end else if (cls == cea_pkg::ClsAddrGen) begin
			r.result = it.use_base ? it.src_b + imm : imm;
		end else if (cls == cea_pkg::ClsReadFirst) begin
			r.result = hi_lo_first;
		end else if (cls == cea_pkg::ClsReadSec) begin
			r.result = hi_lo_second;
		end
		return r;
	endfunction

	function automatic logic [31:0] pick_operand();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return '1;
			3: return '0;
			4: return 32'd1;
			5, 6: return $urandom_range(0, 40) - 20;
			default: return $urandom;
		endcase
	endfunction

	function automatic cea_pkg::in_item_t random_instr();
		cea_pkg::in_item_t it;
		it.op_class = ($urandom_range(0, 30) == 0) ? 6'($urandom_range(32, 63))
			: 6'($urandom_range(0, 31));
		it.func = ($urandom_range(0, 15) == 0) ? 5'($urandom_range(0, 31))
			: (it.op_class == cea_pkg::ClsPairImm || it.op_class == cea_pkg::ClsPairReg)
			? 5'($urandom_range(0, 3)) : 5'($urandom_range(0, 17));
		it.src_a = pick_operand();
		it.src_b = ($urandom_range(0, 5) == 0) ? it.src_a : pick_operand();
		it.immediate = ($urandom_range(0, 5) == 0) ? it.src_a : pick_operand();
		it.jump_target = $urandom;
		it.next_pc = $urandom;
		it.use_base = 1'($urandom);
		return it;
	endfunction

	// directed corner cases, then random instructions
	initial begin
		cea_pkg::in_item_t it;
		logic [31:0] edge_vals[4] = '{32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 32'd0};
		it = '0;
		foreach (edge_vals[i]) begin
			it = random_instr();
			it.op_class = cea_pkg::ClsAluReg; it.func = cea_pkg::FnDiv;
			it.src_a = 32'h8000_0000; it.src_b = edge_vals[i];
			pending_instrs.push_back(it);
		end
		it.op_class = cea_pkg::ClsPairReg; it.func = cea_pkg::PfSdiv; it.src_b = '1;
		pending_instrs.push_back(it);
		it.op_class = cea_pkg::ClsReadFirst; pending_instrs.push_back(it);
		it.op_class = cea_pkg::ClsReadSec; pending_instrs.push_back(it);
		it.op_class = cea_pkg::ClsPairImm; it.func = cea_pkg::PfUmul;
		it.src_a = '1; it.immediate = '1; pending_instrs.push_back(it);
		it.op_class = cea_pkg::ClsReadSec; pending_instrs.push_back(it);
		it.op_class = cea_pkg::ClsPairReg; it.func = cea_pkg::PfUdiv; it.src_b = 0;
		pending_instrs.push_back(it);
		it.op_class = cea_pkg::ClsReadFirst; pending_instrs.push_back(it);
		it.op_class = cea_pkg::ClsAluImm; it.func = cea_pkg::FnRemu; it.immediate = 0;
		pending_instrs.push_back(it);
		it.op_class = cea_pkg::ClsNegNot; it.func = cea_pkg::NnNeg;
		it.src_a = 32'h8000_0000;
		pending_instrs.push_back(it);
		it.func = cea_pkg::NnNot; pending_instrs.push_back(it);
		it.op_class = cea_pkg::ClsAddrGen; it.use_base = 1; it.src_b = '1; it.immediate = '1;
		pending_instrs.push_back(it);
		it.op_class = 6'd63; pending_instrs.push_back(it);
		it.op_class = cea_pkg::ClsAluReg; it.func = 5'd31; pending_instrs.push_back(it);
		it.op_class = cea_pkg::ClsPairReg; pending_instrs.push_back(it);
		it.op_class = cea_pkg::ClsJumpRegLk; pending_instrs.push_back(it);
		repeat (1440) pending_instrs.push_back(random_instr());
		repeat (11) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;
	end

	// sender: offers queued instructions with random gaps
	always @(negedge clk) begin
		if (arst_n) begin
			// a new item only once the offered one has been taken
			if (!in_valid || in_taken) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					in_valid <= 1'b0;
				end else if (pending_instrs.size() > 0) begin
					in_data <= pending_instrs.pop_front();
					in_valid <= 1'b1;
					gap_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 60)
						: ($urandom_range(0, 1) ? 0 : $urandom_range(0, 3));
				end else begin
					in_valid <= 1'b0;
					stimulus_done <= 1'b1;
				end
			end
		end
	end

	// receiver: random stalls plus one long hold-off
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_off > 0) begin
				hold_off <= hold_off - 1;
				out_ready <= 1'b0;
			end else if (cycle_count == 3000) begin
				hold_off <= 400;
				out_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if ($urandom_range(0, 4) == 0)
					stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 80)
						: $urandom_range(1, 3);
			end
		end
	end

	// predict at input transfer, compare at output transfer
	always @(posedge clk) begin
		cea_pkg::out_item_t exp_r;
		cycle_count <= cycle_count + 1;
		in_taken <= arst_n && in_valid && in_ready;
		if (arst_n && in_valid && in_ready)
			expected_results.push_back(execute_instr(in_data));
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				$display("%0t unexpected result %h", $time, out_data);
				errors <= errors + 1;
			end else begin
				exp_r = expected_results.pop_front();
				if (exp_r !== out_data) begin
					$display({"%0t mismatch expected res=%h bt=%b lk=%b dz=%b",
						" actual res=%h bt=%b lk=%b dz=%b"},
						$time, exp_r.result, exp_r.branch_taken, exp_r.link_write,
						exp_r.div_zero, out_data.result, out_data.branch_taken,
						out_data.link_write, out_data.div_zero);
					errors <= errors + 1;
				end
			end
		end
	end

	// end of run and timeout
	initial begin
		wait (stimulus_done && expected_results.size() == 0);
		repeat (60) @(posedge clk);
		if (errors == 0 && expected_results.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		wait (cycle_count == 600000);
		$display("Regression FAIL");
		$finish;
	end
endmodule
